/* design/iidl_pkg.sv */
// Shared constants, codes and types for the indexed insert/delete list unit.
package iidl_pkg;

    // List depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request kinds
    localparam logic [1:0] REQ_INSERT     = 2'd0;
    localparam logic [1:0] REQ_APPEND     = 2'd1;
    localparam logic [1:0] REQ_DELETE     = 2'd2;
    localparam logic [1:0] REQ_DELETE_END = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] at;
    } iidl_cmd_t;

endpackage

/* design/iidl_req_if.sv */
// Request channel: valid/ready handshake with the request payload.
interface iidl_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         req_type;
    logic [iidl_pkg::POS_W-1:0]         position;
    logic signed [iidl_pkg::WORD_W-1:0] new_value;

    modport source (output valid, output req_type, output position, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input new_value,
                    output ready);
endinterface

/* design/iidl_rsp_if.sv */
// Result channel: valid/ready handshake with the result payload.
interface iidl_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic signed [iidl_pkg::WORD_W-1:0] removed_value;
    logic [4:0]                         entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

/* design/indexed_insert_delete_list_unit.sv */
// Top level: request decode, count, row of list cells and result register.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | req_type[1:0], position[4:0], new_value[31:0] signed
//  rsp     | out | valid/ready | status[1:0], removed_value[31:0] signed, entry_count[4:0]
//
// One request per cycle unless a stalled result holds the result register; its result
// appears there the next cycle. All cells shift in the same cycle, at any position.
// Reset clears the count and result valid; cell contents are unknown until written.
// A stalled result holds; a new request is taken while the result is being taken.
module indexed_insert_delete_list_unit (
    input  logic         clk,
    input  logic         rst_n,
    iidl_req_if.sink     req,
    iidl_rsp_if.source   rsp
);

    logic [iidl_pkg::CNT_W-1:0]         count_reg;
    logic [iidl_pkg::CNT_W-1:0]         count_next;
    logic                               rsp_valid_reg;
    logic [1:0]                         status_reg;
    logic [1:0]                         status_next;
    logic signed [iidl_pkg::WORD_W-1:0] removed_reg;
    logic signed [iidl_pkg::WORD_W-1:0] removed_next;
    logic [4:0]                         ecount_reg;
    logic [iidl_pkg::CMP_W-1:0]         count_ext;
    logic [iidl_pkg::CMP_W-1:0]         next_ext;
    logic                               accept;
    logic                               is_ins;
    logic                               ins_ok;
    logic                               del_ok;
    iidl_pkg::iidl_cmd_t                cmd;
    logic signed [iidl_pkg::WORD_W-1:0] cell_word [iidl_pkg::CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign count_ext = iidl_pkg::CMP_W'(count_reg);
    assign is_ins    = (req.req_type == iidl_pkg::REQ_INSERT) ||
                       (req.req_type == iidl_pkg::REQ_APPEND);

    // Decode: target index, status and the command for the cells
    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        status_next = iidl_pkg::ST_OK;
        cmd.at      = iidl_pkg::CMP_W'(req.position);
        case (req.req_type)
            iidl_pkg::REQ_APPEND:
            begin
                cmd.at = count_ext;
            end
            iidl_pkg::REQ_DELETE_END:
            begin
                cmd.at = count_ext - iidl_pkg::CMP_W'(1);
            end
            default:
            begin
                cmd.at = iidl_pkg::CMP_W'(req.position);
            end
        endcase
        if (is_ins)
        begin
            if (cmd.at > count_ext)
            begin
                status_next = iidl_pkg::ST_RANGE;
            end
            else if (count_reg >= iidl_pkg::CNT_W'(iidl_pkg::CAPACITY))
            begin
                status_next = iidl_pkg::ST_FULL;
            end
            else
            begin
                ins_ok = 1'b1;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                status_next = iidl_pkg::ST_EMPTY;
            end
            else if (cmd.at >= count_ext)
            begin
                status_next = iidl_pkg::ST_RANGE;
            end
            else
            begin
                del_ok = 1'b1;
            end
        end
        cmd.ins = accept && ins_ok;
        cmd.del = accept && del_ok;
    end

    // Word leaving the list on a delete
    assign removed_next = del_ok ? cell_word[cmd.at[iidl_pkg::IDX_W-1:0]] : '0;

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + iidl_pkg::CNT_W'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - iidl_pkg::CNT_W'(1);
        end
    end
    assign next_ext = iidl_pkg::CMP_W'(count_next);

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < iidl_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [iidl_pkg::WORD_W-1:0] left_w;
        logic signed [iidl_pkg::WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = req.new_value;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[i-1];
        end

        if (i == iidl_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = cell_word[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        iidl_cell u_cell (
            .clk        (clk),
            .idx        (iidl_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .new_word   (req.new_value),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i])
        );
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            ecount_reg  <= next_ext[4:0];
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.entry_count   = ecount_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= iidl_pkg::CNT_W'(iidl_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ins_ok) |=> (count_reg == $past(count_reg) + iidl_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");

    a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !ins_ok && !del_ok) |=> $stable(count_reg))
        else $error("failed request changed the count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != iidl_pkg::ST_OK)) |-> (removed_reg == '0))
        else $error("failed request returned a word");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (ecount_reg == iidl_pkg::CMP_W'(count_reg)))
        else $error("result count differs from list count");

endmodule

/* design/iidl_cell.sv */
// One list slot: holds a word, loads the new word on an insert at its slot and takes one from a neighbor on a shift.
module iidl_cell (
    input  logic                               clk,
    input  logic [iidl_pkg::IDX_W-1:0]         idx,
    input  iidl_pkg::iidl_cmd_t                cmd,
    input  logic signed [iidl_pkg::WORD_W-1:0] new_word,
    input  logic signed [iidl_pkg::WORD_W-1:0] left_word,
    input  logic signed [iidl_pkg::WORD_W-1:0] right_word,
    output logic signed [iidl_pkg::WORD_W-1:0] word
);

    logic signed [iidl_pkg::WORD_W-1:0] word_reg;
    logic signed [iidl_pkg::WORD_W-1:0] word_next;
    logic [iidl_pkg::CMP_W-1:0]         my_pos;

    assign my_pos = iidl_pkg::CMP_W'(idx);

    // Insert: slot at target loads the new word, slots above shift up.
    // Delete: target and above shift down.
    always_comb
    begin
        word_next = word_reg;
        if (cmd.ins && (my_pos == cmd.at))
        begin
            word_next = new_word;
        end
        else if (cmd.ins && (my_pos > cmd.at))
        begin
            word_next = left_word;
        end
        else if (cmd.del && (my_pos >= cmd.at))
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* verif/iidl_list_checker.sv */
// Checker for the list unit: tracks the list contents, predicts each result and compares.
`timescale 1ns / 100ps

module iidl_list_checker
    import iidl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    iidl_req_if  req,
    iidl_rsp_if  rsp,
    output int   mismatches,
    output int   pending
);

    // One predicted result
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] removed;
        logic [4:0]               count;
    } list_result_t;

    // Shadow copy of the list
    logic signed [WORD_W-1:0] words [CAPACITY];
    int                       fill;

    list_result_t expected_results [$];

    // Apply one request to the shadow list and return the result it should give
    function automatic list_result_t apply_request(input logic [1:0] kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [WORD_W-1:0] word);
        list_result_t r;
        int           at;
        r.status  = ST_OK;
        r.removed = '0;
        if (kind == REQ_INSERT || kind == REQ_APPEND)
        begin
            at = (kind == REQ_APPEND) ? fill : int'(pos);
            // range check wins over the full check
            if (at > fill)
                r.status = ST_RANGE;
            else if (fill >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (int i = fill; i > at; i--)
                    words[i] = words[i - 1];
                words[at] = word;
                fill++;
            end
        end
        else if (fill == 0)
            r.status = ST_EMPTY;
        else
        begin
            at = (kind == REQ_DELETE_END) ? fill - 1 : int'(pos);
            if (at >= fill)
                r.status = ST_RANGE;
            else
            begin
                r.removed = words[at];
                for (int i = at; i + 1 < fill; i++)
                    words[i] = words[i + 1];
                fill--;
            end
        end
        r.count = fill[4:0];
        return r;
    endfunction

    // Watch both channels; results are checked before the new request is queued
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            fill       = 0;
            mismatches = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d, removed %0d, count %0d",
                             $time, rsp.status, rsp.removed_value, rsp.entry_count);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status: expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.removed_value !== want.removed)
                    begin
                        $display("%0t: removed_value: expected %0d, actual %0d",
                                 $time, want.removed, rsp.removed_value);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.entry_count !== want.count)
                    begin
                        $display("%0t: entry_count: expected %0d, actual %0d",
                                 $time, want.count, rsp.entry_count);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_request(req.req_type, req.position,
                                                         req.new_value));
            pending <= expected_results.size();
        end
    end

endmodule

/* verif/tb_indexed_insert_delete_list_unit.sv */
// Testbench top for the list unit: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module tb_indexed_insert_delete_list_unit;
    import iidl_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;

    // Stimulus shaping state
    int   fill_est;
    bit   send_no_idle;
    int   grow_pct;

    iidl_req_if req_ch ();
    iidl_rsp_if rsp_ch ();

    indexed_insert_delete_list_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    iidl_list_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Known values on every input from time zero
    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_INSERT;
        req_ch.position  <= '0;
        req_ch.new_value <= '0;
        rsp_ch.ready     <= 1'b0;
    end

    // Offer one request after a random gap, wait for it to be taken, track the count
    task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                                input logic signed [WORD_W-1:0] word);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.position  <= pos;
        req_ch.new_value <= word;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        // count only, so that random positions can aim at the live range
        case (kind)
            REQ_INSERT:     if (pos <= fill_est && fill_est < CAPACITY) fill_est++;
            REQ_APPEND:     if (fill_est < CAPACITY) fill_est++;
            REQ_DELETE:     if (fill_est > 0 && pos < fill_est) fill_est--;
            REQ_DELETE_END: if (fill_est > 0) fill_est--;
            default:        ;
        endcase
    endtask

    // Result side: random stalls, stall-free stretches, and one long hold-off
    initial
    begin
        int gap;
        int taken;
        bit no_idle;
        taken   = 0;
        no_idle = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            gap = no_idle ? 0 : $urandom_range(0, 6);
            // long hold-off: the result register fills and the request side stalls
            if (taken == 400)
                gap = 150;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            taken++;
        end
    end

    // Request side and verdict
    initial
    begin
        logic [1:0]               kind;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] word;
        int                       seg_left;
        fill_est     = 0;
        send_no_idle = 1'b0;
        grow_pct     = 50;
        seg_left     = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty deletes, edge values, range errors, fill to full, requests on the full list
        send_request(REQ_DELETE,     5'd0,  32'sd0);
        send_request(REQ_DELETE_END, 5'd0,  32'sd0);
        send_request(REQ_INSERT,     5'd1,  32'sd7);
        send_request(REQ_INSERT,     5'd0,  32'sh7FFF_FFFF);
        send_request(REQ_APPEND,     5'd31, 32'sh8000_0000);
        send_request(REQ_INSERT,     5'd1,  -32'sd1);
        send_request(REQ_INSERT,     5'd3,  32'sd0);
        send_request(REQ_DELETE,     5'd4,  32'sd0);
        send_request(REQ_DELETE,     5'd1,  32'sd0);
        send_request(REQ_DELETE_END, 5'd16, 32'sd0);
        while (fill_est < CAPACITY)
            send_request(REQ_APPEND, 5'd0, $urandom);
        send_request(REQ_INSERT, 5'd5,  32'sd1234);
        send_request(REQ_INSERT, 5'd31, 32'sd99);
        send_request(REQ_APPEND, 5'd0,  -32'sd5);

        // Random: segments that lean toward growing, shrinking or neither
        for (int n = 0; n < 1500; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left     = $urandom_range(40, 160);
                grow_pct     = ($urandom_range(0, 2) == 0) ? 75 :
                               ($urandom_range(0, 1) == 0) ? 25 : 50;
                send_no_idle = ($urandom_range(0, 3) == 0);
            end
            seg_left--;

            // pause once until every result is back
            if (n == 800)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end

            if ($urandom_range(0, 99) < grow_pct)
                kind = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
            else
                kind = $urandom_range(0, 1) ? REQ_DELETE_END : REQ_DELETE;

            // mostly valid positions, some anywhere in the 5-bit range
            if ($urandom_range(0, 9) == 0 || kind == REQ_APPEND || kind == REQ_DELETE_END)
                pos = POS_W'($urandom_range(0, 31));
            else if (kind == REQ_INSERT)
                pos = POS_W'($urandom_range(0, fill_est));
            else
                pos = (fill_est > 0) ? POS_W'($urandom_range(0, fill_est - 1)) : 5'd0;

            case ($urandom_range(0, 15))
                0:       word = 32'sh7FFF_FFFF;
                1:       word = 32'sh8000_0000;
                2:       word = 32'sd0;
                3:       word = -32'sd1;
                default: word = $urandom;
            endcase

            send_request(kind, pos, word);
        end
        req_ch.valid <= 1'b0;

        // Drain, then wait for anything stray
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* indexed_insert_delete_list_unit.f */
design/iidl_pkg.sv
design/iidl_req_if.sv
design/iidl_rsp_if.sv
design/iidl_cell.sv
design/indexed_insert_delete_list_unit.sv
verif/iidl_list_checker.sv
verif/tb_indexed_insert_delete_list_unit.sv
